/* src/rsmp_pkg.sv */
`timescale 1ns / 1ps

package rsmp_pkg;

  // Limits of the block
  localparam int MAX_STEPS        = 256;
  localparam int MAX_PROFILE      = 64;
  localparam int SINE_TABLE_DEPTH = 1024;

  // Field widths
  localparam int COORD_W = 16;
  localparam int PIDX_W  = 6;
  localparam int STEP_W  = 8;
  localparam int IDX_W   = 14;
  localparam int STEPS_W = 9;
  localparam int LEN_W   = 7;
  localparam int PH_W    = 16;
  localparam int SIN_W   = 16;
  localparam int PROD_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Sine table geometry: full turn in TAB_W bits, one quarter stored
  localparam int TAB_W      = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_W      = TAB_W - 2;
  localparam int QTR_DEPTH  = SINE_TABLE_DEPTH / 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd2;

  // Register reset values
  localparam logic [STEPS_W-1:0] NUM_STEPS_RST   = 9'd20;
  localparam logic [LEN_W-1:0]   PROFILE_LEN_RST = 7'd2;
  localparam logic [PH_W-1:0]    PHASE_STEP_RST  = 16'd3277;

  // Fixed point constants for the table build (Q30)
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [PIDX_W-1:0]         point_index;
    logic [STEP_W-1:0]         step_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic [IDX_W-1:0]          vertex_slot;
    logic                      quad_valid;
    logic [IDX_W-1:0]          tri_a_first;
    logic [IDX_W-1:0]          tri_a_second;
    logic [IDX_W-1:0]          tri_a_third;
    logic [IDX_W-1:0]          tri_b_first;
    logic [IDX_W-1:0]          tri_b_second;
    logic [IDX_W-1:0]          tri_b_third;
  } out_item_t;

  typedef logic signed [SIN_W-1:0] sine_qtr_t [QTR_DEPTH];

  // Sine of quarter-turn position m, Q1.14; Taylor series to degree 13 in Q30
  function automatic logic signed [SIN_W-1:0] sine_quarter(int unsigned m);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] s;
    x  = 64'(m) << (32 - TAB_W);
    t  = (x * HALF_PI_Q30) >> 30;
    t2 = (t * t) >> 30;
    p  = Q30_ONE;
    p  = Q30_ONE - (((t2 * p) >> 30) / 64'd156);
    p  = Q30_ONE - (((t2 * p) >> 30) / 64'd110);
    p  = Q30_ONE - (((t2 * p) >> 30) / 64'd72);
    p  = Q30_ONE - (((t2 * p) >> 30) / 64'd42);
    p  = Q30_ONE - (((t2 * p) >> 30) / 64'd20);
    p  = Q30_ONE - (((t2 * p) >> 30) / 64'd6);
    s  = (t * p) >> 30;
    return SIN_W'((s + 64'd32768) >> 16);
  endfunction

  function automatic sine_qtr_t build_quarter();
    sine_qtr_t q;
    for (int m = 0; m < QTR_DEPTH; m++) begin
      q[m] = sine_quarter(m);
    end
    return q;
  endfunction

  // First quarter of the table, and its end point (quarter turn)
  localparam sine_qtr_t SINE_QTR = build_quarter();
  localparam logic signed [SIN_W-1:0] SIN_PEAK = sine_quarter(QTR_DEPTH);

endpackage

/* src/revolution_surface_mesh_point_top.sv */
`timescale 1ns / 1ps

// Surface-of-revolution mesh point: takes one profile point per transfer,
// rotates it about the Y axis by step_index * phase_step (65536 = one turn)
// and returns the vertex, its slot and the two triangles of the quad to the
// next profile point on the next meridian. Four-stage pipeline (index and
// phase multiply, sine/cosine lookup, products, round and saturate): one item
// per cycle sustained; each item passes through the stage registers in order,
// and out_valid rises when it reaches the output register; the input
// ready drops only while the output register holds an untaken result and the
// stages behind it are full. Configuration written while idle takes effect
// for the next item.
module revolution_surface_mesh_point_top
  import rsmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  // Round Q.26 sum to Q3.12 (floor of (s + half)), then saturate
  function automatic logic signed [COORD_W-1:0] round_sat(logic signed [PROD_W-1:0] s);
    logic signed [PROD_W:0] b;
    logic signed [PROD_W:0] r;
    b = (PROD_W+1)'(s) + (PROD_W+1)'(8192);
    r = b >>> 14;
    if (r > (PROD_W+1)'(32767)) begin
      return 16'sh7fff;
    end else if (r < -(PROD_W+1)'(32768)) begin
      return 16'sh8000;
    end else begin
      return COORD_W'(r);
    end
  endfunction

  // Configuration registers
  logic [STEPS_W-1:0] num_steps_r;
  logic [LEN_W-1:0]   profile_len_r;
  logic [PH_W-1:0]    phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_steps_r   <= NUM_STEPS_RST;
      profile_len_r <= PROFILE_LEN_RST;
      phase_step_r  <= PHASE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_STEPS:   num_steps_r   <= cfg_data[STEPS_W-1:0];
        CFG_PROFILE_LEN: profile_len_r <= cfg_data[LEN_W-1:0];
        CFG_PHASE_STEP:  phase_step_r  <= cfg_data[PH_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance chain
  logic v1_r, v2_r, v3_r, vo_r;
  logic adv1, adv2, adv3, adv_out;

  assign adv_out   = !vo_r || out_ready;
  assign adv3      = !v3_r || adv_out;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_ready  = adv1;
  assign out_valid = vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1)    v1_r <= in_valid;
      if (adv2)    v2_r <= v1_r;
      if (adv3)    v3_r <= v2_r;
      if (adv_out) vo_r <= v3_r;
    end
  end

  // Stage 1: phase, meridian offsets, quad flag
  logic [STEPS_W-1:0] steps_eff;
  logic [LEN_W-1:0]   len_eff;
  logic [STEP_W-1:0]  next_step;
  logic [PH_W-1:0]    phase_nxt;
  logic [IDX_W-1:0]   cur_nxt;
  logic [IDX_W-1:0]   nxt_nxt;
  logic               qv_nxt;

  always_comb begin
    steps_eff = (32'(num_steps_r) > MAX_STEPS) ? STEPS_W'(MAX_STEPS) : num_steps_r;
    len_eff   = (32'(profile_len_r) > MAX_PROFILE) ? LEN_W'(MAX_PROFILE) : profile_len_r;
    next_step = ((STEPS_W'(in_data.step_index) + STEPS_W'(1)) < steps_eff)
                ? in_data.step_index + STEP_W'(1) : '0;
    phase_nxt = PH_W'(24'(in_data.step_index) * 24'(phase_step_r));
    cur_nxt   = IDX_W'(15'(in_data.step_index) * 15'(len_eff));
    nxt_nxt   = IDX_W'(15'(next_step) * 15'(len_eff));
    qv_nxt    = (LEN_W'(in_data.point_index) + LEN_W'(1)) < len_eff;
  end

  logic signed [COORD_W-1:0] px1_r, py1_r, pz1_r;
  logic [PH_W-1:0]           phase1_r;
  logic [IDX_W-1:0]          cur1_r, nxt1_r;
  logic [PIDX_W-1:0]         idx1_r;
  logic                      qv1_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      px1_r    <= in_data.point_x;
      py1_r    <= in_data.point_y;
      pz1_r    <= in_data.point_z;
      phase1_r <= phase_nxt;
      cur1_r   <= cur_nxt;
      nxt1_r   <= nxt_nxt;
      idx1_r   <= in_data.point_index;
      qv1_r    <= qv_nxt;
    end
  end

  // Stage 2: sine/cosine lookup and vertex indices
  logic signed [SIN_W-1:0] sin2_r, cos2_r;

  rsmp_sincos u_sincos (
    .clk   (clk),
    .en    (adv2),
    .phase (phase1_r),
    .sin_r (sin2_r),
    .cos_r (cos2_r)
  );

  logic [IDX_W-1:0] i_ext;
  logic [IDX_W-1:0] slot_nxt, a1_nxt, a2_nxt, a3_nxt;

  always_comb begin
    i_ext    = IDX_W'(idx1_r);
    slot_nxt = i_ext + cur1_r;
    a1_nxt   = qv1_r ? i_ext + nxt1_r : '0;
    a2_nxt   = qv1_r ? i_ext + IDX_W'(1) + nxt1_r : '0;
    a3_nxt   = qv1_r ? i_ext + IDX_W'(1) + cur1_r : '0;
  end

  logic signed [COORD_W-1:0] px2_r, py2_r, pz2_r;
  logic [IDX_W-1:0]          slot2_r, a12_r, a22_r, a32_r, b22_r;
  logic                      qv2_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      px2_r   <= px1_r;
      py2_r   <= py1_r;
      pz2_r   <= pz1_r;
      slot2_r <= slot_nxt;
      a12_r   <= a1_nxt;
      a22_r   <= a2_nxt;
      a32_r   <= a3_nxt;
      b22_r   <= qv1_r ? slot_nxt : '0;
      qv2_r   <= qv1_r;
    end
  end

  // Stage 3: the four rotation products
  logic signed [PROD_W-1:0] xc3_r, zs3_r, xs3_r, zc3_r;
  logic signed [COORD_W-1:0] py3_r;
  logic [IDX_W-1:0]          slot3_r, a13_r, a23_r, a33_r, b23_r;
  logic                      qv3_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      xc3_r   <= px2_r * cos2_r;
      zs3_r   <= pz2_r * sin2_r;
      xs3_r   <= px2_r * sin2_r;
      zc3_r   <= pz2_r * cos2_r;
      py3_r   <= py2_r;
      slot3_r <= slot2_r;
      a13_r   <= a12_r;
      a23_r   <= a22_r;
      a33_r   <= a32_r;
      b23_r   <= b22_r;
      qv3_r   <= qv2_r;
    end
  end

  // Stage 4: sum, round, saturate into the output register
  logic signed [PROD_W-1:0] rx_sum, rz_sum;

  assign rx_sum = xc3_r + zs3_r;
  assign rz_sum = zc3_r - xs3_r;

  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_r.vertex_x     <= round_sat(rx_sum);
      out_r.vertex_y     <= py3_r;
      out_r.vertex_z     <= round_sat(rz_sum);
      out_r.vertex_slot  <= slot3_r;
      out_r.quad_valid   <= qv3_r;
      out_r.tri_a_first  <= a13_r;
      out_r.tri_a_second <= a23_r;
      out_r.tri_a_third  <= a33_r;
      out_r.tri_b_first  <= a33_r;
      out_r.tri_b_second <= b23_r;
      out_r.tri_b_third  <= a13_r;
    end
  end

  assign out_data = out_r;

endmodule

/* src/rsmp_sincos.sv */
`timescale 1ns / 1ps

module rsmp_sincos
  import rsmp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [PH_W-1:0]         phase,
  output logic signed [SIN_W-1:0] sin_r,
  output logic signed [SIN_W-1:0] cos_r
);

  // Full-turn lookup built from the stored quarter by symmetry
  function automatic logic signed [SIN_W-1:0] turn_lookup(logic [TAB_W-1:0] k);
    logic [QTR_W-1:0]        low;
    logic signed [SIN_W-1:0] mag;
    low = k[QTR_W-1:0];
    if (k[QTR_W] && (low == '0)) begin
      mag = SIN_PEAK;
    end else if (k[QTR_W]) begin
      mag = SINE_QTR[QTR_W'(~low + 1'b1)];
    end else begin
      mag = SINE_QTR[low];
    end
    return k[TAB_W-1] ? -mag : mag;
  endfunction

  logic [TAB_W-1:0] sin_idx;
  logic [TAB_W-1:0] cos_idx;

  // Cosine sits a quarter turn ahead
  assign sin_idx = phase[PH_W-1 -: TAB_W];
  assign cos_idx = sin_idx + TAB_W'(QTR_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= turn_lookup(sin_idx);
      cos_r <= turn_lookup(cos_idx);
    end
  end

endmodule
